[rtl/bbps_pkg.sv]
// Shared types and constants for the bouncing ball stepper.
// Used by the channel interfaces, the top level and the checker.
`default_nettype none

package bbps_pkg;

    // Fixed widths of the channel fields and the configuration registers.
    localparam int FIELD_W   = 24;
    localparam int COEF_W    = 16;
    localparam int REG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int REQ_W     = 2;

    typedef logic [REQ_W-1:0]     t_req;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Request codes.
    localparam t_req REQ_TICK    = 2'd0;
    localparam t_req REQ_LAUNCH  = 2'd1;
    localparam t_req REQ_RESTART = 2'd2;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_GRAVITY  = 3'd0;
    localparam t_cfg_idx CFG_DAMPING  = 3'd1;
    localparam t_cfg_idx CFG_FRICTION = 3'd2;
    localparam t_cfg_idx CFG_STOP_THR = 3'd3;
    localparam t_cfg_idx CFG_RADIUS   = 3'd4;
    localparam t_cfg_idx CFG_FLOOR_Y  = 3'd5;
    localparam t_cfg_idx CFG_RIGHT_X  = 3'd6;
    localparam t_cfg_idx CFG_START_Y  = 3'd7;

    // Configuration values after reset.
    localparam logic [COEF_W-1:0] GRAVITY_RST  = 16'd128;
    localparam logic [COEF_W-1:0] DAMPING_RST  = 16'd45875;
    localparam logic [COEF_W-1:0] FRICTION_RST = 16'd64225;
    localparam logic [REG_W-1:0]  STOP_THR_RST = 20'd256;
    localparam logic [REG_W-1:0]  RADIUS_RST   = 20'd2560;
    localparam logic [REG_W-1:0]  FLOOR_Y_RST  = 20'd99840;
    localparam logic [REG_W-1:0]  RIGHT_X_RST  = 20'd202240;
    localparam logic [REG_W-1:0]  START_Y_RST  = 20'd112640;

    // Horizontal start offset from the left limit, in whole pixels.
    localparam int START_OFFSET_PX = 100;

endpackage

`default_nettype wire

[rtl/bbps_if.sv]
// Valid/ready channel interfaces of the bouncing ball stepper.
// Depends on bbps_pkg for field widths and code types.
`default_nettype none

interface bbps_req_if
    import bbps_pkg::*;
;
    logic                       valid;
    logic                       ready;
    t_req                       req_type;
    logic                       hold;
    logic signed [FIELD_W-1:0]  launch_vx;
    logic signed [FIELD_W-1:0]  launch_vy;

    modport source (output valid, req_type, hold, launch_vx, launch_vy, input ready);
    modport sink   (input valid, req_type, hold, launch_vx, launch_vy, output ready);
endinterface

interface bbps_res_if
    import bbps_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  pos_x;
    logic signed [FIELD_W-1:0]  pos_y;
    logic signed [FIELD_W-1:0]  vel_x;
    logic signed [FIELD_W-1:0]  vel_y;
    logic                       rolling;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, rolling, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, rolling, output ready);
endinterface

interface bbps_cfg_if
    import bbps_pkg::*;
;
    logic               valid;
    logic               ready;
    t_cfg_idx           index;
    logic [REG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/bouncing_ball_physics_step.sv]
// Bouncing ball stepper: position, velocity and rolling flag in signed fixed point.
// Depends on bbps_pkg and the channel interfaces in bbps_if.sv.
// Launch, restart, held tick and unused codes go straight to the done state; a tick passes
// move, floor, wall, top and friction, and each bounce or friction product (at most 4) adds
// multiply and write-back. One request at a time; an untaken result keeps the block busy.
// Reset (synchronous, active low) loads the default configuration and the start state.
`default_nettype none

module bouncing_ball_physics_step
    import bbps_pkg::*;
#(
    parameter int VALUE_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bbps_req_if.sink    i_req,
    bbps_res_if.source  o_res,
    bbps_cfg_if.sink    i_cfg
);

    localparam int W      = VALUE_WIDTH;
    // Working width for sums and compares against the unsigned registers.
    localparam int XW     = ((W > REG_W + 1) ? W : REG_W + 1) + 3;
    localparam int PW     = W + COEF_W;
    localparam int MIN_SPEED    = ((1 << FRAC_BITS) + 9) / 10;
    localparam int START_OFFSET = START_OFFSET_PX << FRAC_BITS;

    localparam logic signed [XW-1:0] VMAX_X = (XW'(1) <<< (W - 1)) - XW'(1);
    localparam logic signed [XW-1:0] VMIN_X = -(XW'(1) <<< (W - 1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOVE,
        S_FLOOR,
        S_WALL,
        S_TOP,
        S_FRIC,
        S_MUL,
        S_WB,
        S_DONE
    } t_state;

    // Saturate a wide value to the state range.
    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
        if (v > VMAX_X) begin
            return VMAX_X[W-1:0];
        end else if (v < VMIN_X) begin
            return VMIN_X[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
        return XW'(v);
    endfunction

    function automatic logic signed [XW-1:0] uext(input logic [REG_W-1:0] v);
        return $signed(XW'(v));
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    // Control and sequencing.
    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // Configuration registers.
    logic [COEF_W-1:0] r_gravity, r_damping, r_friction;
    logic [REG_W-1:0]  r_stop, r_radius, r_floor, r_right, r_start_y;

    // Ball state.
    logic signed [W-1:0] r_x, n_x, r_y, n_y, r_vx, n_vx, r_vy, n_vy;
    logic                r_on, n_on;

    // Shared multiplier operands and product.
    logic [W-1:0]      r_mul_mag, n_mul_mag;
    logic [COEF_W-1:0] r_mul_k, n_mul_k;
    logic              r_mul_neg, n_mul_neg;
    logic              r_mul_to_y, n_mul_to_y;
    logic              r_mul_fric, n_mul_fric;
    logic [PW-1:0]     r_prod, n_prod;

    // Output register.
    logic                      r_out_valid, n_out_valid;
    logic signed [FIELD_W-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic signed [FIELD_W-1:0] r_out_vx, n_out_vx, r_out_vy, n_out_vy;
    logic                      r_out_on, n_out_on;

    logic req_fire;
    logic signed [W-1:0] radius_s;
    logic signed [W-1:0] rst_x, rst_y;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_fire    = i_req.valid && i_req.ready;

    assign radius_s = sat(uext(r_radius));
    assign rst_x    = sat(uext(r_radius) + XW'(START_OFFSET));
    assign rst_y    = sat(uext(r_start_y));

    assign o_res.valid   = r_out_valid;
    assign o_res.pos_x   = r_out_x;
    assign o_res.pos_y   = r_out_y;
    assign o_res.vel_x   = r_out_vx;
    assign o_res.vel_y   = r_out_vy;
    assign o_res.rolling = r_out_on;

    // Sequencer and datapath next-state logic.
    always_comb begin
        logic [W-1:0]          prod_hi;
        logic signed [W-1:0]   scaled;
        logic signed [XW-1:0]  wide_x, wide_y, wide_vx, wide_vy;

        n_state     = r_state;
        n_ret       = r_ret;
        n_x         = r_x;
        n_y         = r_y;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_on        = r_on;
        n_mul_mag   = r_mul_mag;
        n_mul_k     = r_mul_k;
        n_mul_neg   = r_mul_neg;
        n_mul_to_y  = r_mul_to_y;
        n_mul_fric  = r_mul_fric;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_vx    = r_out_vx;
        n_out_vy    = r_out_vy;
        n_out_on    = r_out_on;

        prod_hi = r_prod[PW-1:COEF_W];
        scaled  = r_mul_neg ? -$signed(prod_hi) : $signed(prod_hi);
        wide_x  = ext(r_x);
        wide_y  = ext(r_y);
        wide_vx = ext(r_vx);
        wide_vy = ext(r_vy);

        // The result beat leaves when the sink takes it.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_DONE;
                    unique case (i_req.req_type)
                        REQ_TICK: begin
                            if (!i_req.hold) begin
                                n_state = S_MOVE;
                            end
                        end
                        REQ_LAUNCH: begin
                            n_vx = sat(XW'(i_req.launch_vx));
                            n_vy = sat(XW'(i_req.launch_vy));
                        end
                        REQ_RESTART: begin
                            n_x  = rst_x;
                            n_y  = rst_y;
                            n_vx = '0;
                            n_vy = '0;
                            n_on = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Move by the velocity and add gravity.
            S_MOVE: begin
                n_x     = sat(wide_x + wide_vx);
                n_y     = sat(wide_y + wide_vy);
                n_vy    = sat(wide_vy + uext(REG_W'(r_gravity)));
                n_state = S_FLOOR;
            end

            // Floor contact: stop when slow, otherwise bounce.
            S_FLOOR: begin
                n_state = S_WALL;
                if (wide_y > uext(r_floor)) begin
                    n_y = sat(uext(r_floor));
                    if ((XW'(mag(r_vy))) < (XW'(r_stop))) begin
                        n_vy = '0;
                        n_on = 1'b1;
                    end else begin
                        n_on       = 1'b0;
                        n_mul_mag  = mag(r_vy);
                        n_mul_k    = r_damping;
                        n_mul_neg  = ~r_vy[W-1];
                        n_mul_to_y = 1'b1;
                        n_mul_fric = 1'b0;
                        n_ret      = S_WALL;
                        n_state    = S_MUL;
                    end
                end
            end

            // Side walls, left before right.
            S_WALL: begin
                n_state    = S_TOP;
                n_mul_mag  = mag(r_vx);
                n_mul_k    = r_damping;
                n_mul_neg  = ~r_vx[W-1];
                n_mul_to_y = 1'b0;
                n_mul_fric = 1'b0;
                n_ret      = S_TOP;
                if (wide_x < ext(radius_s)) begin
                    n_x     = radius_s;
                    n_state = S_MUL;
                end else if (wide_x > uext(r_right)) begin
                    n_x     = sat(uext(r_right));
                    n_state = S_MUL;
                end
            end

            // Top limit; applied after the floor, so it wins when they conflict.
            S_TOP: begin
                n_state = S_FRIC;
                if (wide_y < ext(radius_s)) begin
                    n_y        = radius_s;
                    n_mul_mag  = mag(r_vy);
                    n_mul_k    = r_damping;
                    n_mul_neg  = ~r_vy[W-1];
                    n_mul_to_y = 1'b1;
                    n_mul_fric = 1'b0;
                    n_ret      = S_FRIC;
                    n_state    = S_MUL;
                end
            end

            // Rolling friction on the horizontal velocity.
            S_FRIC: begin
                n_state = S_DONE;
                if (r_on) begin
                    n_mul_mag  = mag(r_vx);
                    n_mul_k    = r_friction;
                    n_mul_neg  = r_vx[W-1];
                    n_mul_to_y = 1'b0;
                    n_mul_fric = 1'b1;
                    n_ret      = S_DONE;
                    n_state    = S_MUL;
                end
            end

            // Shared multiplier: magnitude times Q0.16 coefficient.
            S_MUL: begin
                n_prod  = PW'(r_mul_mag) * PW'(r_mul_k);
                n_state = S_WB;
            end

            // Write the scaled velocity back with its sign.
            S_WB: begin
                if (r_mul_fric && (prod_hi < W'(MIN_SPEED))) begin
                    scaled = '0;
                end
                if (r_mul_to_y) begin
                    n_vy = scaled;
                end else begin
                    n_vx = scaled;
                end
                n_state = r_ret;
            end

            // Load the result once the output register is free.
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_x     = wide_x[FIELD_W-1:0];
                    n_out_y     = wide_y[FIELD_W-1:0];
                    n_out_vx    = wide_vx[FIELD_W-1:0];
                    n_out_vy    = wide_vy[FIELD_W-1:0];
                    n_out_on    = r_on;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gravity   <= GRAVITY_RST;
            r_damping   <= DAMPING_RST;
            r_friction  <= FRICTION_RST;
            r_stop      <= STOP_THR_RST;
            r_radius    <= RADIUS_RST;
            r_floor     <= FLOOR_Y_RST;
            r_right     <= RIGHT_X_RST;
            r_start_y   <= START_Y_RST;
            r_x         <= sat(uext(RADIUS_RST) + XW'(START_OFFSET));
            r_y         <= sat(uext(START_Y_RST));
            r_vx        <= '0;
            r_vy        <= '0;
            r_on        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
            r_x         <= n_x;
            r_y         <= n_y;
            r_vx        <= n_vx;
            r_vy        <= n_vy;
            r_on        <= n_on;
            r_mul_mag   <= n_mul_mag;
            r_mul_k     <= n_mul_k;
            r_mul_neg   <= n_mul_neg;
            r_mul_to_y  <= n_mul_to_y;
            r_mul_fric  <= n_mul_fric;
            r_prod      <= n_prod;
            r_out_x     <= n_out_x;
            r_out_y     <= n_out_y;
            r_out_vx    <= n_out_vx;
            r_out_vy    <= n_out_vy;
            r_out_on    <= n_out_on;

            // Configuration beat.
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_GRAVITY:  r_gravity  <= i_cfg.data[COEF_W-1:0];
                    CFG_DAMPING:  r_damping  <= i_cfg.data[COEF_W-1:0];
                    CFG_FRICTION: r_friction <= i_cfg.data[COEF_W-1:0];
                    CFG_STOP_THR: r_stop     <= i_cfg.data;
                    CFG_RADIUS:   r_radius   <= i_cfg.data;
                    CFG_FLOOR_Y:  r_floor    <= i_cfg.data;
                    CFG_RIGHT_X:  r_right    <= i_cfg.data;
                    CFG_START_Y:  r_start_y  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bbps_checker.sv]
// Port-level checks for the bouncing ball stepper, bound to the top level.
// Depends on bbps_pkg for field widths.
`default_nettype none

module bbps_checker
    import bbps_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       res_valid,
    input wire logic                       res_ready,
    input wire logic signed [FIELD_W-1:0]  pos_x,
    input wire logic signed [FIELD_W-1:0]  pos_y,
    input wire logic signed [FIELD_W-1:0]  vel_x,
    input wire logic signed [FIELD_W-1:0]  vel_y,
    input wire logic                       rolling
);

    // The block works on one request at a time: ready drops after each request beat.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request side stayed ready after a request beat");

    // A result that is not taken stays offered.
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> ($stable(pos_x) && $stable(pos_y) && $stable(vel_x)
            && $stable(vel_y) && $stable(rolling)))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid)
        else $error("result offered right after reset");

endmodule

bind bouncing_ball_physics_step bbps_checker u_bbps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .req_valid (i_req.valid),
    .req_ready (i_req.ready),
    .res_valid (o_res.valid),
    .res_ready (o_res.ready),
    .pos_x     (o_res.pos_x),
    .pos_y     (o_res.pos_y),
    .vel_x     (o_res.vel_x),
    .vel_y     (o_res.vel_y),
    .rolling   (o_res.rolling)
);

`default_nettype wire

[verif/bbps_ball_checker.sv]
// Scoreboard for the bouncing ball stepper: watches the request, result and register channels.
// Keeps its own copy of the registers and the ball, predicts each result and compares it.
// Depends on bbps_pkg and the channel interfaces in bbps_if.sv.
`timescale 1ns / 1ps

module bbps_ball_checker
    import bbps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bbps_req_if  i_req,
    bbps_res_if  i_res,
    bbps_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int     FRAC_BITS    = 8;
    localparam longint FIELD_TOP    = (longint'(1) <<< (FIELD_W - 1)) - 1;
    localparam longint FIELD_BOTTOM = -(longint'(1) <<< (FIELD_W - 1));
    // Smallest horizontal speed that survives rolling: 0.1 pixel, rounded up.
    localparam longint ROLL_MIN_SPEED = ((longint'(1) <<< FRAC_BITS) + 9) / 10;
    localparam longint START_OFFSET   = longint'(START_OFFSET_PX) <<< FRAC_BITS;

    typedef struct {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [FIELD_W-1:0] vel_x;
        logic signed [FIELD_W-1:0] vel_y;
        logic                      rolling;
    } ball_snapshot_t;

    // Register copies, held as plain integers for the arithmetic below.
    longint gravity_q, damping_q, friction_q, stop_thr_q;
    longint radius_q, floor_y_q, right_x_q, start_y_q;

    // Predicted ball state.
    longint ball_x, ball_y, speed_x, speed_y;
    logic   ball_rolling;

    ball_snapshot_t predicted_snapshots[$];
    int             mismatches = 0;

    function automatic longint clamp_field(longint v);
        if (v > FIELD_TOP) return FIELD_TOP;
        if (v < FIELD_BOTTOM) return FIELD_BOTTOM;
        return v;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Scales a speed by an unsigned Q0.16 factor, truncating toward zero; flip reverses it.
    function automatic longint scale_speed(longint v, longint coef, bit flip);
        longint m;
        m = (magnitude(v) * coef) >>> COEF_W;
        return ((v < 0) != flip) ? -m : m;
    endfunction

    function automatic void restart_ball();
        ball_x       = clamp_field(radius_q + START_OFFSET);
        ball_y       = clamp_field(start_y_q);
        speed_x      = 0;
        speed_y      = 0;
        ball_rolling = 1'b0;
    endfunction

    function automatic void load_default_regs();
        gravity_q  = longint'(GRAVITY_RST);
        damping_q  = longint'(DAMPING_RST);
        friction_q = longint'(FRICTION_RST);
        stop_thr_q = longint'(STOP_THR_RST);
        radius_q   = longint'(RADIUS_RST);
        floor_y_q  = longint'(FLOOR_Y_RST);
        right_x_q  = longint'(RIGHT_X_RST);
        start_y_q  = longint'(START_Y_RST);
    endfunction

    // The coefficient registers keep only their low bits.
    function automatic void store_reg(t_cfg_idx idx, logic [REG_W-1:0] data);
        case (idx)
            CFG_GRAVITY:  gravity_q  = longint'(data[COEF_W-1:0]);
            CFG_DAMPING:  damping_q  = longint'(data[COEF_W-1:0]);
            CFG_FRICTION: friction_q = longint'(data[COEF_W-1:0]);
            CFG_STOP_THR: stop_thr_q = longint'(data);
            CFG_RADIUS:   radius_q   = longint'(data);
            CFG_FLOOR_Y:  floor_y_q  = longint'(data);
            CFG_RIGHT_X:  right_x_q  = longint'(data);
            CFG_START_Y:  start_y_q  = longint'(data);
            default: ;
        endcase
    endfunction

    // One physics tick: move, gravity, floor, side walls, top, then rolling friction.
    function automatic void advance_ball();
        longint radius;
        radius  = clamp_field(radius_q);
        ball_x  = clamp_field(ball_x + speed_x);
        ball_y  = clamp_field(ball_y + speed_y);
        speed_y = clamp_field(speed_y + gravity_q);

        if (ball_y > floor_y_q) begin
            ball_y = clamp_field(floor_y_q);
            if (magnitude(speed_y) < stop_thr_q) begin
                speed_y      = 0;
                ball_rolling = 1'b1;
            end else begin
                ball_rolling = 1'b0;
                speed_y      = scale_speed(speed_y, damping_q, 1'b1);
            end
        end

        if (ball_x < radius) begin
            ball_x  = radius;
            speed_x = scale_speed(speed_x, damping_q, 1'b1);
        end else if (ball_x > right_x_q) begin
            ball_x  = clamp_field(right_x_q);
            speed_x = scale_speed(speed_x, damping_q, 1'b1);
        end

        // The top clamp comes last, so it wins over a floor set above it.
        if (ball_y < radius) begin
            ball_y  = radius;
            speed_y = scale_speed(speed_y, damping_q, 1'b1);
        end

        if (ball_rolling) begin
            speed_x = scale_speed(speed_x, friction_q, 1'b0);
            if (magnitude(speed_x) < ROLL_MIN_SPEED) speed_x = 0;
        end
    endfunction

    function automatic void apply_request(t_req kind, logic hold,
                                          logic signed [FIELD_W-1:0] vx,
                                          logic signed [FIELD_W-1:0] vy);
        case (kind)
            REQ_TICK: begin
                if (!hold) advance_ball();
            end
            REQ_LAUNCH: begin
                speed_x = clamp_field(longint'(vx));
                speed_y = clamp_field(longint'(vy));
            end
            REQ_RESTART: restart_ball();
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                        logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        ball_snapshot_t snap;
        if (!i_rst_n) begin
            load_default_regs();
            restart_ball();
            predicted_snapshots.delete();
        end else begin
            // Result beat: compare against the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                if (predicted_snapshots.size() == 0) begin
                    $display("%0t: unexpected result beat: pos (%0d, %0d) vel (%0d, %0d) rolling %0b",
                             $time, i_res.pos_x, i_res.pos_y, i_res.vel_x, i_res.vel_y,
                             i_res.rolling);
                    mismatches++;
                end else begin
                    snap = predicted_snapshots.pop_front();
                    check_field("pos_x", snap.pos_x, i_res.pos_x);
                    check_field("pos_y", snap.pos_y, i_res.pos_y);
                    check_field("vel_x", snap.vel_x, i_res.vel_x);
                    check_field("vel_y", snap.vel_y, i_res.vel_y);
                    check_field("rolling", FIELD_W'(snap.rolling), FIELD_W'(i_res.rolling));
                end
            end

            if (i_cfg.valid && i_cfg.ready) store_reg(i_cfg.index, i_cfg.data);

            // Request beat: every request reports the ball state after it.
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.req_type, i_req.hold, i_req.launch_vx, i_req.launch_vy);
                snap.pos_x   = ball_x[FIELD_W-1:0];
                snap.pos_y   = ball_y[FIELD_W-1:0];
                snap.vel_x   = speed_x[FIELD_W-1:0];
                snap.vel_y   = speed_y[FIELD_W-1:0];
                snap.rolling = ball_rolling;
                predicted_snapshots.push_back(snap);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= predicted_snapshots.size();
    end

endmodule

[verif/tb_bouncing_ball_physics_step.sv]
// Top of the bouncing ball stepper testbench: clock, reset, register phases and request traffic.
// Depends on bbps_pkg, the channel interfaces, the stepper and bbps_ball_checker.
`timescale 1ns / 1ps

module tb_bouncing_ball_physics_step;
    import bbps_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int LONG_HOLD_OFF   = 300;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int REG_COUNT       = 2 ** CFG_IDX_W;

    // Request code the block does not define.
    localparam t_req REQ_UNUSED = 2'd3;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    typedef enum int {
        PLAN_DEFAULT,
        PLAN_ALL_MAX,
        PLAN_ALL_ZERO,
        PLAN_CONFLICT,
        PLAN_RANDOM
    } reg_plan_e;

    localparam reg_plan_e PHASE_ORDER [RANDOM_PHASES] = '{
        PLAN_DEFAULT, PLAN_ALL_MAX, PLAN_ALL_ZERO, PLAN_RANDOM,
        PLAN_RANDOM, PLAN_RANDOM, PLAN_RANDOM, PLAN_RANDOM
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             random_started;
    int               fail_count;
    int               pending;
    int               send_calm;
    logic [REG_W-1:0] reg_plan [REG_COUNT];

    bbps_req_if req_ch ();
    bbps_res_if res_ch ();
    bbps_cfg_if cfg_ch ();

    bouncing_ball_physics_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    bbps_ball_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_field();
        return FIELD_W'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Launch speeds: mostly a few pixels per tick, some full width, some at the extremes.
    function automatic logic signed [FIELD_W-1:0] pick_speed();
        logic signed [FIELD_W-1:0] speed;
        int unsigned               span;
        case ($urandom_range(0, 9))
            0: speed = rand_field();
            1: speed = rand_bit() ? FIELD_MAX : FIELD_MIN;
            default: begin
                span  = 1 << $urandom_range(2, 13);
                speed = FIELD_W'($urandom_range(0, span));
                if (rand_bit()) speed = -speed;
            end
        endcase
        return speed;
    endfunction

    function automatic logic [REG_W-1:0] reg_word(int unsigned value);
        return value[REG_W-1:0];
    endfunction

    // Coefficient registers get random junk above their low bits.
    function automatic logic [REG_W-1:0] coef_word(int unsigned value);
        logic [31:0] junk;
        junk = $urandom;
        return {junk[REG_W-COEF_W-1:0], value[COEF_W-1:0]};
    endfunction

    function automatic void plan_regs(reg_plan_e kind);
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        case (kind)
            PLAN_ALL_MAX: begin
                foreach (reg_plan[i]) reg_plan[i] = '1;
            end
            PLAN_ALL_ZERO: begin
                foreach (reg_plan[i]) reg_plan[i] = '0;
            end
            PLAN_RANDOM: begin
                reg_plan[CFG_GRAVITY]  = coef_word(wide ? $urandom : $urandom_range(0, 600));
                reg_plan[CFG_DAMPING]  = coef_word($urandom);
                reg_plan[CFG_FRICTION] = coef_word(wide ? $urandom
                                                        : $urandom_range(55000, 65535));
                reg_plan[CFG_STOP_THR] = reg_word(wide ? $urandom : $urandom_range(0, 2048));
                reg_plan[CFG_RADIUS]   = reg_word(wide ? $urandom : $urandom_range(0, 8192));
                reg_plan[CFG_FLOOR_Y]  = reg_word(wide ? $urandom
                                                       : $urandom_range(20000, 150000));
                reg_plan[CFG_RIGHT_X]  = reg_word(wide ? $urandom
                                                       : $urandom_range(30000, 250000));
                reg_plan[CFG_START_Y]  = reg_word($urandom);
            end
            default: begin
                reg_plan[CFG_GRAVITY]  = REG_W'(GRAVITY_RST);
                reg_plan[CFG_DAMPING]  = REG_W'(DAMPING_RST);
                reg_plan[CFG_FRICTION] = REG_W'(FRICTION_RST);
                reg_plan[CFG_STOP_THR] = STOP_THR_RST;
                reg_plan[CFG_RADIUS]   = RADIUS_RST;
                reg_plan[CFG_FLOOR_Y]  = FLOOR_Y_RST;
                reg_plan[CFG_RIGHT_X]  = RIGHT_X_RST;
                reg_plan[CFG_START_Y]  = START_Y_RST;
                // Floor above the top limit: both clamps apply and the top one wins.
                if (kind == PLAN_CONFLICT) begin
                    reg_plan[CFG_FLOOR_Y] = reg_word(1000);
                    reg_plan[CFG_RADIUS]  = reg_word(5000);
                end
            end
        endcase
    endfunction

    // Writes every register back to back; valid stays high between beats.
    task automatic program_regs();
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_idx'(i);
            cfg_ch.data  <= reg_plan[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Offers one request after a random gap and returns on its beat.
    task automatic send_req(input t_req kind, input logic hold,
                            input logic signed [FIELD_W-1:0] vx,
                            input logic signed [FIELD_W-1:0] vy);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.hold      <= hold;
        req_ch.launch_vx <= vx;
        req_ch.launch_vy <= vy;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_tick(input logic hold);
        send_req(REQ_TICK, hold, rand_field(), rand_field());
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Throws: an optional restart, a launch, then a run of ticks with some held.
    // Now and then a bare run of ticks or an unused code breaks the pattern.
    // Every request sent counts toward the goal.
    task automatic run_throws(input int item_goal);
        int counted;
        int run_len;
        counted = 0;
        while (counted < item_goal) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_req(REQ_RESTART, rand_bit(), rand_field(), rand_field());
                    counted++;
                end
                1: begin
                    send_req(REQ_UNUSED, rand_bit(), rand_field(), rand_field());
                    counted++;
                end
                default: ;
            endcase
            if ($urandom_range(0, 7) != 0) begin
                send_req(REQ_LAUNCH, rand_bit(), pick_speed(), pick_speed());
                counted++;
            end
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(3, 40);
            repeat (run_len) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick(1'b1);
                end else begin
                    send_tick(1'b0);
                end
                counted++;
            end
        end
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off under load.
    initial begin
        int stall_left;
        int calm_left;
        bit held_off;
        stall_left   = 0;
        calm_left    = 0;
        held_off     = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && random_started && res_ch.valid) begin
                stall_left = LONG_HOLD_OFF;
                held_off   = 1'b1;
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 59) == 0) begin
                    calm_left = $urandom_range(30, 150);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Run limit.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        random_started   = 1'b0;
        send_calm        = 0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_TICK;
        req_ch.hold      = 1'b0;
        req_ch.launch_vx = '0;
        req_ch.launch_vy = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_GRAVITY;
        cfg_ch.data      = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan_regs(PLAN_DEFAULT);
        program_regs();

        // The first tick drops the ball onto the floor slowly enough to roll.
        send_req(REQ_TICK, 1'b0, '0, '0);
        send_req(REQ_TICK, 1'b1, '0, '0);
        // Launches at the field extremes saturate the position and hit both walls.
        send_req(REQ_LAUNCH, 1'b0, FIELD_MAX, FIELD_MIN);
        send_req(REQ_TICK, 1'b0, '0, '0);
        send_req(REQ_TICK, 1'b0, '0, '0);
        send_req(REQ_LAUNCH, 1'b1, FIELD_MIN, FIELD_MAX);
        send_req(REQ_TICK, 1'b0, FIELD_MAX, FIELD_MIN);
        send_req(REQ_TICK, 1'b0, '0, '0);
        // An unused code is ignored and reports the state.
        send_req(REQ_UNUSED, 1'b1, FIELD_MAX, FIELD_MAX);
        // Restart, settle, then throw upward while rolling so friction acts in the air.
        send_req(REQ_RESTART, 1'b1, '0, '0);
        send_req(REQ_TICK, 1'b0, '0, '0);
        send_req(REQ_LAUNCH, 1'b1, 24'sh000300, -24'sh000800);
        repeat (4) send_req(REQ_TICK, 1'b0, '0, '0);
        // A slow roll drops under 0.1 pixel and stops.
        send_req(REQ_LAUNCH, 1'b0, 24'sd20, '0);
        send_req(REQ_TICK, 1'b0, '0, '0);
        drain_requests();

        plan_regs(PLAN_CONFLICT);
        program_regs();
        send_req(REQ_RESTART, 1'b0, '0, '0);
        send_req(REQ_TICK, 1'b0, '0, '0);
        send_req(REQ_LAUNCH, 1'b0, 24'sh000200, 24'sh000400);
        send_req(REQ_TICK, 1'b0, '0, '0);
        send_req(REQ_TICK, 1'b0, '0, '0);
        drain_requests();

        // Random phases, each under its own register setting.
        random_started <= 1'b1;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            plan_regs(PHASE_ORDER[p]);
            program_regs();
            run_throws(ITEMS_PER_PHASE);
            drain_requests();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
